// ===== src/bmhq_pkg.sv =====
// Shared types, sizes and codes of the binary min-heap queue.
`default_nettype none
package bmhq_pkg;

	localparam int unsigned DEPTH   = 256;
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned ADDR_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W   = ADDR_W + 1;
	localparam int unsigned FKEY_W  = 32;
	localparam int unsigned ID_W    = 9;
	localparam int unsigned COUNT_W = 9;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [FKEY_W-1:0]  fkey_t;
	typedef logic [ID_W-1:0]    id_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		key_t key;
		id_t  id;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_EMPTY    = 2'd2
	} status_t;

	localparam logic FUNC_INSERT  = 1'b0;
	localparam logic FUNC_EXTRACT = 1'b1;

	typedef struct packed {
		logic   we;
		addr_t  waddr;
		entry_t wdata;
		addr_t  raddr;
	} mem_req_t;

endpackage
`default_nettype wire

// ===== src/bmhq_if.sv =====
// Request and response channel interfaces of the binary min-heap queue.
`default_nettype none
interface bmhq_req_if;
	logic            valid;
	logic            ready;
	logic            func;
	bmhq_pkg::fkey_t entry_key;
	bmhq_pkg::id_t   entry_id;

	modport source (output valid, output func, output entry_key, output entry_id, input ready);
	modport sink   (input valid, input func, input entry_key, input entry_id, output ready);
endinterface

interface bmhq_rsp_if;
	logic              valid;
	logic              ready;
	bmhq_pkg::status_t status;
	bmhq_pkg::fkey_t   min_key;
	bmhq_pkg::id_t     min_id;
	bmhq_pkg::count_t  count;

	modport source (output valid, output status, output min_key, output min_id, output count,
		input ready);
	modport sink   (input valid, input status, input min_key, input min_id, input count,
		output ready);
endinterface
`default_nettype wire

// ===== src/binary_min_heap_queue_unit.sv =====
// Top level of the binary min-heap queue: sequencer and entry RAM.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | func, entry_key, entry_id
//  rsp     | out | valid / ready | status, min_key, min_id, count
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Insert: per level climbed, the parent is read, then the parent or the entry is written;
// the climb ends with a write at the root or where the parent is not larger.
// Extract: the last entry is read, then per level descended the left and right children are
// read and the smaller child moves up, or the entry is written on a leaf or a lost compare.
// Overflow and empty requests go straight from idle to the final step.
// Reset clears the count and the response valid flag; the entry RAM is not cleared.
// A held response stalls the sequencer only at its last step; the next request still enters.
`default_nettype none
module binary_min_heap_queue_unit (
	input  logic       clk,
	input  logic       arst_n,
	bmhq_req_if.sink   req,
	bmhq_rsp_if.source rsp
);

	bmhq_pkg::mem_req_t                  mem;
	bmhq_pkg::entry_t                    rd_data;
	logic [bmhq_pkg::ENTRY_W-1:0]        rdata_raw;

	bmhq_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.mem     (mem),
		.rd_data (rd_data)
	);

	bmhq_ram #(
		.WIDTH (bmhq_pkg::ENTRY_W),
		.DEPTH (bmhq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata_raw)
	);

	assign rd_data = bmhq_pkg::entry_t'(rdata_raw);

endmodule
`default_nettype wire

// ===== src/bmhq_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module bmhq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== src/bmhq_seq.sv =====
// Heap sequencer: insert sift-up and extract sift-down over the entry RAM.
`default_nettype none
module bmhq_seq (
	input  logic               clk,
	input  logic               arst_n,
	bmhq_req_if.sink           req,
	bmhq_rsp_if.source         rsp,
	output bmhq_pkg::mem_req_t mem,
	input  bmhq_pkg::entry_t   rd_data
);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_UP   = 9'b000000010,
		S_UPC  = 9'b000000100,
		S_EX1  = 9'b000001000,
		S_EX2  = 9'b000010000,
		S_DL   = 9'b000100000,
		S_DR   = 9'b001000000,
		S_DC   = 9'b010000000,
		S_FIN  = 9'b100000000
	} state_t;

	state_t             state_q, state_d;
	bmhq_pkg::cnt_t     cnt_q;
	bmhq_pkg::addr_t    pos_q;
	bmhq_pkg::entry_t   x_q;
	bmhq_pkg::entry_t   lft_q;
	bmhq_pkg::entry_t   min_q;
	bmhq_pkg::status_t  st_q;
	logic               ovalid_q;
	bmhq_pkg::status_t  ost_q;
	bmhq_pkg::fkey_t    okey_q;
	bmhq_pkg::id_t      oid_q;
	bmhq_pkg::count_t   ocnt_q;

	logic               accept;
	logic               out_free;
	logic               is_full;
	logic               is_empty;
	bmhq_pkg::cnt_t     lc;
	bmhq_pkg::cnt_t     rc;
	bmhq_pkg::addr_t    parent;
	logic               up_lt;
	logic               left_lt;
	logic               right_lt;
	bmhq_pkg::key_t     cur_key;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign out_free  = !ovalid_q || rsp.ready;
	assign is_full   = (cnt_q == bmhq_pkg::cnt_t'(bmhq_pkg::DEPTH));
	assign is_empty  = (cnt_q == '0);

	assign lc       = {pos_q, 1'b1};
	assign rc       = bmhq_pkg::cnt_t'({pos_q, 1'b0}) + bmhq_pkg::cnt_t'(2);
	assign parent   = bmhq_pkg::addr_t'((pos_q - bmhq_pkg::addr_t'(1)) >> 1);
	assign up_lt    = x_q.key < rd_data.key;
	assign left_lt  = lft_q.key < x_q.key;
	assign cur_key  = left_lt ? lft_q.key : x_q.key;
	assign right_lt = (rc < cnt_q) && (rd_data.key < cur_key);

	assign rsp.valid   = ovalid_q;
	assign rsp.status  = ost_q;
	assign rsp.min_key = okey_q;
	assign rsp.min_id  = oid_q;
	assign rsp.count   = ocnt_q;

	always_comb begin
		state_d   = state_q;
		mem.we    = 1'b0;
		mem.waddr = pos_q;
		mem.wdata = x_q;
		mem.raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.func == bmhq_pkg::FUNC_EXTRACT) begin
						state_d = is_empty ? S_FIN : S_EX1;
					end else begin
						state_d = is_full ? S_FIN : S_UP;
					end
				end
			end
			S_UP: begin
				if (pos_q == '0) begin
					mem.we  = 1'b1;
					state_d = S_FIN;
				end else begin
					mem.raddr = parent;
					state_d   = S_UPC;
				end
			end
			S_UPC: begin
				mem.we = 1'b1;
				if (up_lt) begin
					mem.wdata = rd_data;
					state_d   = S_UP;
				end else begin
					state_d = S_FIN;
				end
			end
			S_EX1: begin
				mem.raddr = cnt_q[bmhq_pkg::ADDR_W-1:0];
				state_d   = S_EX2;
			end
			S_EX2: begin
				state_d = S_DL;
			end
			S_DL: begin
				if (lc >= cnt_q) begin
					mem.we  = 1'b1;
					state_d = S_FIN;
				end else begin
					mem.raddr = lc[bmhq_pkg::ADDR_W-1:0];
					state_d   = S_DR;
				end
			end
			S_DR: begin
				mem.raddr = rc[bmhq_pkg::ADDR_W-1:0];
				state_d   = S_DC;
			end
			S_DC: begin
				mem.we = 1'b1;
				if (right_lt) begin
					mem.wdata = rd_data;
					state_d   = S_DL;
				end else if (left_lt) begin
					mem.wdata = lft_q;
					state_d   = S_DL;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req.func == bmhq_pkg::FUNC_INSERT && !is_full) begin
					cnt_q <= cnt_q + bmhq_pkg::cnt_t'(1);
				end else if (req.func == bmhq_pkg::FUNC_EXTRACT && !is_empty) begin
					cnt_q <= cnt_q - bmhq_pkg::cnt_t'(1);
				end
			end
			if (state_q == S_FIN && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					x_q.key <= bmhq_pkg::key_t'(req.entry_key);
					x_q.id  <= req.entry_id;
					pos_q   <= cnt_q[bmhq_pkg::ADDR_W-1:0];
					min_q   <= '0;
					if (req.func == bmhq_pkg::FUNC_EXTRACT) begin
						st_q <= is_empty ? bmhq_pkg::STAT_EMPTY : bmhq_pkg::STAT_OK;
					end else begin
						st_q <= is_full ? bmhq_pkg::STAT_OVERFLOW : bmhq_pkg::STAT_OK;
					end
				end
			end
			S_UPC: begin
				if (up_lt) begin
					pos_q <= parent;
				end
			end
			S_EX1: begin
				min_q <= rd_data;
			end
			S_EX2: begin
				x_q   <= rd_data;
				pos_q <= '0;
			end
			S_DR: begin
				lft_q <= rd_data;
			end
			S_DC: begin
				if (right_lt) begin
					pos_q <= rc[bmhq_pkg::ADDR_W-1:0];
				end else if (left_lt) begin
					pos_q <= lc[bmhq_pkg::ADDR_W-1:0];
				end
			end
			S_FIN: begin
				if (out_free) begin
					ost_q  <= st_q;
					okey_q <= bmhq_pkg::fkey_t'(min_q.key);
					oid_q  <= min_q.id;
					ocnt_q <= bmhq_pkg::count_t'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/bmhq_checker.sv =====
// Port-level checker of the binary min-heap queue and its bind.
`default_nettype none
module bmhq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input bmhq_pkg::status_t rsp_status,
	input bmhq_pkg::fkey_t   rsp_min_key,
	input bmhq_pkg::id_t     rsp_min_id,
	input bmhq_pkg::count_t  rsp_count
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_min_key)
			&& $stable(rsp_min_id) && $stable(rsp_status))
		else $error("response changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != bmhq_pkg::STAT_OK |-> rsp_min_key == '0 && rsp_min_id == '0)
		else $error("failed request returned a nonzero entry");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bmhq_pkg::STAT_OVERFLOW
			|-> rsp_count == bmhq_pkg::count_t'(bmhq_pkg::DEPTH))
		else $error("overflow reported below full");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bmhq_pkg::STAT_EMPTY |-> rsp_count == '0)
		else $error("empty reported with entries held");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= bmhq_pkg::count_t'(bmhq_pkg::DEPTH))
		else $error("count beyond capacity");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_min_key (rsp.min_key),
	.rsp_min_id  (rsp.min_id),
	.rsp_count   (rsp.count)
);
`default_nettype wire

// ===== verif/binary_min_heap_queue_unit_tb.sv =====
// Testbench of the binary min-heap queue: directed and random requests against a heap model.
`timescale 1ns / 1ps
module binary_min_heap_queue_unit_tb;

	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 64;
	localparam int unsigned MAX_REPORTS = 10;

	typedef struct {
		bmhq_pkg::status_t status;
		bmhq_pkg::fkey_t   min_key;
		bmhq_pkg::id_t     min_id;
		bmhq_pkg::count_t  count;
	} heap_result_t;

	logic clk;
	logic arst_n;

	bmhq_req_if req_ch ();
	bmhq_rsp_if rsp_ch ();

	binary_min_heap_queue_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	bmhq_pkg::key_t heap_key_m [bmhq_pkg::DEPTH];
	bmhq_pkg::id_t  heap_id_m  [bmhq_pkg::DEPTH];
	int unsigned    heap_size;
	heap_result_t   pending_results [$];
	int unsigned    mismatch_count;
	int unsigned    fail_count;
	int unsigned    quiet_cycles;
	int unsigned    sink_hold_cycles;
	bit             idle_on;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void swap_entries(int unsigned a, int unsigned b);
		bmhq_pkg::key_t tk;
		bmhq_pkg::id_t  ti;
		tk = heap_key_m[a];
		ti = heap_id_m[a];
		heap_key_m[a] = heap_key_m[b];
		heap_id_m[a] = heap_id_m[b];
		heap_key_m[b] = tk;
		heap_id_m[b] = ti;
	endfunction

	function automatic heap_result_t heap_apply(logic op, bmhq_pkg::fkey_t key_in,
		bmhq_pkg::id_t id_in);
		heap_result_t r;
		int unsigned  pos;
		int unsigned  parent;
		int unsigned  lc;
		int unsigned  rc;
		int unsigned  best;
		r.status = bmhq_pkg::STAT_OK;
		r.min_key = '0;
		r.min_id = '0;
		if (op == bmhq_pkg::FUNC_INSERT) begin
			if (heap_size >= bmhq_pkg::DEPTH) begin
				r.status = bmhq_pkg::STAT_OVERFLOW;
			end else begin
				pos = heap_size;
				heap_key_m[pos] = bmhq_pkg::key_t'(key_in);
				heap_id_m[pos] = id_in;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!(heap_key_m[pos] < heap_key_m[parent]))
						break;
					swap_entries(pos, parent);
					pos = parent;
				end
				heap_size++;
			end
		end else if (heap_size == 0) begin
			r.status = bmhq_pkg::STAT_EMPTY;
		end else begin
			r.min_key = bmhq_pkg::fkey_t'(heap_key_m[0]);
			r.min_id = heap_id_m[0];
			heap_key_m[0] = heap_key_m[heap_size - 1];
			heap_id_m[0] = heap_id_m[heap_size - 1];
			heap_size--;
			pos = 0;
			forever begin
				best = pos;
				lc = 2 * pos + 1;
				rc = 2 * pos + 2;
				if (lc < heap_size && heap_key_m[lc] < heap_key_m[best])
					best = lc;
				if (rc < heap_size && heap_key_m[rc] < heap_key_m[best])
					best = rc;
				if (best == pos)
					break;
				swap_entries(pos, best);
				pos = best;
			end
		end
		r.count = bmhq_pkg::count_t'(heap_size);
		return r;
	endfunction

	function automatic bmhq_pkg::fkey_t pick_key();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2, 3: return bmhq_pkg::fkey_t'($urandom_range(0, 15));
			4: return 32'hFFFF_FFF0 | bmhq_pkg::fkey_t'($urandom_range(0, 15));
			default: return bmhq_pkg::fkey_t'($urandom);
		endcase
	endfunction

	task automatic send_request(logic op, bmhq_pkg::fkey_t key_in, bmhq_pkg::id_t id_in);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		req_ch.func = op;
		req_ch.entry_key = key_in;
		req_ch.entry_id = id_in;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(heap_apply(op, key_in, id_in));
	endtask

	task automatic send_mixed(int n);
		int unsigned target;
		logic        op;
		target = 0;
		for (int i = 0; i < n; i++) begin
			if (i % 48 == 0) begin
				case ($urandom_range(0, 5))
					0: target = 0;
					1: target = $urandom_range(64, bmhq_pkg::DEPTH);
					default: target = $urandom_range(0, 40);
				endcase
			end
			if (heap_size < target)
				op = ($urandom_range(0, 3) != 0) ? bmhq_pkg::FUNC_INSERT
					: bmhq_pkg::FUNC_EXTRACT;
			else
				op = ($urandom_range(0, 3) != 0) ? bmhq_pkg::FUNC_EXTRACT
					: bmhq_pkg::FUNC_INSERT;
			send_request(op, pick_key(), bmhq_pkg::id_t'($urandom_range(0, 511)));
		end
	endtask

	task automatic test_empty_extract();
		send_request(bmhq_pkg::FUNC_EXTRACT, '1, '1);
		send_request(bmhq_pkg::FUNC_EXTRACT, '0, '0);
	endtask

	task automatic test_directed_order();
		send_request(bmhq_pkg::FUNC_INSERT, 32'd7, 9'd10);
		send_request(bmhq_pkg::FUNC_INSERT, 32'd7, 9'd11);
		send_request(bmhq_pkg::FUNC_INSERT, '1, 9'd511);
		send_request(bmhq_pkg::FUNC_INSERT, 32'd7, 9'd12);
		send_request(bmhq_pkg::FUNC_INSERT, '0, 9'd0);
		send_request(bmhq_pkg::FUNC_INSERT, 32'd3, 9'h155);
		send_request(bmhq_pkg::FUNC_INSERT, 32'd7, 9'h0AA);
		send_request(bmhq_pkg::FUNC_INSERT, 32'h8000_0000, 9'd256);
		repeat (9) send_request(bmhq_pkg::FUNC_EXTRACT, bmhq_pkg::fkey_t'($urandom),
			bmhq_pkg::id_t'($urandom));
	endtask

	task automatic test_fill_and_overflow();
		while (heap_size < bmhq_pkg::DEPTH)
			send_request(bmhq_pkg::FUNC_INSERT, pick_key(),
				bmhq_pkg::id_t'($urandom_range(0, 511)));
		send_request(bmhq_pkg::FUNC_INSERT, '0, '0);
		send_request(bmhq_pkg::FUNC_INSERT, '1, '1);
		repeat (bmhq_pkg::DEPTH + 1)
			send_request(bmhq_pkg::FUNC_EXTRACT, pick_key(), bmhq_pkg::id_t'($urandom));
	endtask

	task automatic test_random_mix();
		send_mixed(700);
	endtask

	task automatic test_output_stall();
		sink_hold_cycles = 300;
		send_mixed(12);
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		send_mixed(200);
		while (heap_size > 0)
			send_request(bmhq_pkg::FUNC_EXTRACT, pick_key(), bmhq_pkg::id_t'($urandom));
		send_request(bmhq_pkg::FUNC_EXTRACT, '0, '0);
	endtask

	initial begin
		int burst;
		burst = 0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_hold_cycles > 0) begin
				rsp_ch.ready = 1'b0;
				sink_hold_cycles--;
			end else if (burst > 0) begin
				rsp_ch.ready = 1'b0;
				burst--;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready = 1'b0;
				burst = $urandom_range(1, 9) - 1;
			end else begin
				rsp_ch.ready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		heap_result_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				fail_count++;
				if (mismatch_count < MAX_REPORTS)
					$display("%0t: response with no request pending: status %0d key %0h id %0d",
						$realtime, rsp_ch.status, rsp_ch.min_key, rsp_ch.min_id);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.status !== want.status || rsp_ch.min_key !== want.min_key ||
					rsp_ch.min_id !== want.min_id || rsp_ch.count !== want.count) begin
					fail_count++;
					if (mismatch_count < MAX_REPORTS)
						$display({"%0t: mismatch exp status %0d key %0h id %0d count %0d,",
							" got status %0d key %0h id %0d count %0d"},
							$realtime, want.status, want.min_key, want.min_id, want.count,
							rsp_ch.status, rsp_ch.min_key, rsp_ch.min_id, rsp_ch.count);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		heap_size = 0;
		mismatch_count = 0;
		fail_count = 0;
		sink_hold_cycles = 0;
		idle_on = 1'b1;
		req_ch.valid = 1'b0;
		req_ch.func = bmhq_pkg::FUNC_INSERT;
		req_ch.entry_key = '0;
		req_ch.entry_id = '0;
		arst_n = 1'b0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_empty_extract();
		test_directed_order();
		test_fill_and_overflow();
		test_random_mix();
		test_output_stall();
		test_full_rate();

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			fail_count++;
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
